// ===== rtl/vfc_pkg.sv =====
// Shared widths, codes and word types of the voxel face culling block.
// No dependencies; every other file imports it.
`default_nettype none
package vfc_pkg;

   localparam int TYPE_W    = 8;
   localparam int POS_W     = 4;
   localparam int DIR_W     = 3;
   localparam int VTX_W     = 17;
   localparam int NUM_DIRS  = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [VTX_W-1:0] VTX_STEP = VTX_W'(4);

   // face directions, in emit order
   localparam logic [DIR_W-1:0] DIR_TOP    = 3'd0;
   localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd3;
   localparam logic [DIR_W-1:0] DIR_FRONT  = 3'd4;
   localparam logic [DIR_W-1:0] DIR_BACK   = 3'd5;

   // register select bit (paddr[2])
   localparam logic CSR_AIR   = 1'b0;
   localparam logic CSR_WATER = 1'b1;

   localparam logic [TYPE_W-1:0] AIR_RESET   = 8'd0;
   localparam logic [TYPE_W-1:0] WATER_RESET = 8'd1;

   typedef struct packed {
      logic                first;
      logic [POS_W-1:0]    x;
      logic [POS_W-1:0]    y;
      logic [POS_W-1:0]    z;
      logic [TYPE_W-1:0]   kind;
      logic                water;
      logic [NUM_DIRS-1:0] mask;
   } voxel_type;

   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [POS_W-1:0]  z;
      logic [DIR_W-1:0]  dir;
      logic [TYPE_W-1:0] kind;
      logic              transparent;
      logic [VTX_W-1:0]  base;
      logic              last;
   } face_word_type;

endpackage
`default_nettype wire

// ===== rtl/vfc_req_if.sv =====
// Input channel: one voxel word with its six neighbor types.
// Depends on vfc_pkg.
`default_nettype none
interface vfc_req_if;
   import vfc_pkg::*;

   logic              valid;
   logic              ready;
   logic              first;
   logic [POS_W-1:0]  pos_x;
   logic [POS_W-1:0]  pos_y;
   logic [POS_W-1:0]  pos_z;
   logic [TYPE_W-1:0] self_type;
   logic [TYPE_W-1:0] nb_top;
   logic [TYPE_W-1:0] nb_bottom;
   logic [TYPE_W-1:0] nb_right;
   logic [TYPE_W-1:0] nb_left;
   logic [TYPE_W-1:0] nb_front;
   logic [TYPE_W-1:0] nb_back;

   modport source (output valid, first, pos_x, pos_y, pos_z, self_type,
                   nb_top, nb_bottom, nb_right, nb_left, nb_front, nb_back,
                   input ready);
   modport sink (input valid, first, pos_x, pos_y, pos_z, self_type,
                 nb_top, nb_bottom, nb_right, nb_left, nb_front, nb_back,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/vfc_rsp_if.sv =====
// Result channel: one visible face word.
// Depends on vfc_pkg.
`default_nettype none
interface vfc_rsp_if;
   import vfc_pkg::*;

   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  face_x;
   logic [POS_W-1:0]  face_y;
   logic [POS_W-1:0]  face_z;
   logic [DIR_W-1:0]  face_dir;
   logic [TYPE_W-1:0] face_type;
   logic              transparent;
   logic [VTX_W-1:0]  base_vertex;
   logic              last;

   modport source (output valid, face_x, face_y, face_z, face_dir, face_type,
                   transparent, base_vertex, last, input ready);
   modport sink (input valid, face_x, face_y, face_z, face_dir, face_type,
                 transparent, base_vertex, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/vfc_lane.sv =====
// One visibility lane: decides whether the face toward one neighbor shows.
// Depends on vfc_pkg.
`default_nettype none
module vfc_lane (
   input  wire logic [vfc_pkg::TYPE_W-1:0] nb_type,
   input  wire logic [vfc_pkg::TYPE_W-1:0] air_code,
   input  wire logic [vfc_pkg::TYPE_W-1:0] water_code,
   input  wire logic                       self_water,
   output logic                            visible
);
   import vfc_pkg::*;

   logic nb_air;
   logic nb_water;

   always_comb begin
      nb_air   = (nb_type == air_code);
      nb_water = (nb_type == water_code);
      visible  = nb_air || (!self_water && nb_water);
   end
endmodule
`default_nettype wire

// ===== rtl/vfc_emit.sv =====
// Merge stage: holds one voxel's face mask, emits its faces lowest direction
// first through an output register and keeps both vertex counters.
// Depends on vfc_pkg and vfc_rsp_if.
`default_nettype none
module vfc_emit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                ld_valid,
   input  wire vfc_pkg::voxel_type  ld_voxel,
   output logic                     ld_ready,
   vfc_rsp_if.source                rsp_chan
);
   import vfc_pkg::*;

   logic [NUM_DIRS-1:0] mask_ff, mask_in;
   voxel_type           vox_ff, vox_in;
   logic [VTX_W-1:0]    solid_cnt_ff, solid_cnt_in;
   logic [VTX_W-1:0]    water_cnt_ff, water_cnt_in;
   logic                out_valid_ff, out_valid_in;
   face_word_type       out_ff, out_in;

   logic [NUM_DIRS-1:0] pick_oh;
   logic [DIR_W-1:0]    pick_dir;
   logic [NUM_DIRS-1:0] rest;
   logic                fire;
   logic                load;
   logic [VTX_W-1:0]    base;

   always_comb begin
      pick_oh  = '0;
      pick_dir = DIR_TOP;
      for (int i = NUM_DIRS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick_oh  = NUM_DIRS'(1) << i;
            pick_dir = DIR_W'(i);
         end
      end
      rest     = mask_ff & ~pick_oh;
      fire     = (mask_ff != '0) && (!out_valid_ff || rsp_chan.ready);
      ld_ready = (mask_ff == '0) || (fire && (rest == '0));
      load     = ld_ready && ld_valid;
      base     = vox_ff.water ? water_cnt_ff : solid_cnt_ff;

      vox_in  = load ? ld_voxel : vox_ff;
      mask_in = load ? ld_voxel.mask : (fire ? rest : mask_ff);

      solid_cnt_in = solid_cnt_ff;
      water_cnt_in = water_cnt_ff;
      if (fire) begin
         if (vox_ff.water) begin
            water_cnt_in = water_cnt_ff + VTX_STEP;
         end else begin
            solid_cnt_in = solid_cnt_ff + VTX_STEP;
         end
      end
      if (load && ld_voxel.first) begin
         solid_cnt_in = '0;
         water_cnt_in = '0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (fire) begin
         out_valid_in       = 1'b1;
         out_in.x           = vox_ff.x;
         out_in.y           = vox_ff.y;
         out_in.z           = vox_ff.z;
         out_in.dir         = pick_dir;
         out_in.kind        = vox_ff.kind;
         out_in.transparent = vox_ff.water;
         out_in.base        = base;
         out_in.last        = (rest == '0);
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         solid_cnt_ff <= '0;
         water_cnt_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         solid_cnt_ff <= solid_cnt_in;
         water_cnt_ff <= water_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vox_ff <= vox_in;
      out_ff <= out_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.face_x      = out_ff.x;
   assign rsp_chan.face_y      = out_ff.y;
   assign rsp_chan.face_z      = out_ff.z;
   assign rsp_chan.face_dir    = out_ff.dir;
   assign rsp_chan.face_type   = out_ff.kind;
   assign rsp_chan.transparent = out_ff.transparent;
   assign rsp_chan.base_vertex = out_ff.base;
   assign rsp_chan.last        = out_ff.last;
endmodule
`default_nettype wire

// ===== rtl/voxel_face_culling.sv =====
// Top level of the voxel face culling block: registers, six lanes, merge stage.
// Depends on vfc_pkg, vfc_req_if, vfc_rsp_if, vfc_lane and vfc_emit.
//
// Usage: req_chan takes one voxel word (position, own type, six neighbor
// types) per handshake; rsp_chan gives one word per visible face, in the
// order top, bottom, right, left, front, back, with last on the final face
// of the voxel. Air voxels and voxels with no visible face give no word.
// Six lanes test all neighbors of a voxel in the cycle it is accepted.
// The first face of a voxel passes the merge stage's mask register and then
// the output register. One face word per cycle leaves the single result
// port while the receiver is ready; the next voxel is taken in the cycle
// its predecessor's final face is issued.
// The APB port holds air_code (address 0) and water_code (address 4);
// write them only while the block is idle. Reset clears both vertex
// counters, sets air_code to 0 and water_code to 1 and drops any pending
// faces. When the receiver stalls, the face word holds in the output
// register and the merge stage waits; input stops once it is full.
`default_nettype none
module voxel_face_culling (
   input  wire logic                           clock,
   input  wire logic                           reset,
   vfc_req_if.sink                             req_chan,
   vfc_rsp_if.source                           rsp_chan,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [vfc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [vfc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [vfc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);
   import vfc_pkg::*;

   logic [TYPE_W-1:0] air_ff, air_in;
   logic [TYPE_W-1:0] water_ff, water_in;
   logic              csr_write;

   logic [TYPE_W-1:0]   nb_types [NUM_DIRS];
   logic [NUM_DIRS-1:0] lane_vis;
   logic                self_air;
   logic                self_water;
   voxel_type           ld_voxel;
   logic                ld_ready;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      air_in   = air_ff;
      water_in = water_ff;
      if (csr_write) begin
         unique case (paddr[2])
            CSR_AIR:   air_in   = pwdata[TYPE_W-1:0];
            CSR_WATER: water_in = pwdata[TYPE_W-1:0];
            default:   air_in   = air_ff;
         endcase
      end
      unique case (paddr[2])
         CSR_AIR:   prdata = CSR_DATA_W'(air_ff);
         CSR_WATER: prdata = CSR_DATA_W'(water_ff);
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         air_ff   <= AIR_RESET;
         water_ff <= WATER_RESET;
      end else begin
         air_ff   <= air_in;
         water_ff <= water_in;
      end
   end

   assign nb_types[DIR_TOP]    = req_chan.nb_top;
   assign nb_types[DIR_BOTTOM] = req_chan.nb_bottom;
   assign nb_types[DIR_RIGHT]  = req_chan.nb_right;
   assign nb_types[DIR_LEFT]   = req_chan.nb_left;
   assign nb_types[DIR_FRONT]  = req_chan.nb_front;
   assign nb_types[DIR_BACK]   = req_chan.nb_back;

   assign self_air   = (req_chan.self_type == air_ff);
   assign self_water = (req_chan.self_type == water_ff);

   for (genvar d = 0; d < NUM_DIRS; d++) begin : g_lane
      vfc_lane u_lane (
         .nb_type    (nb_types[d]),
         .air_code   (air_ff),
         .water_code (water_ff),
         .self_water (self_water),
         .visible    (lane_vis[d])
      );
   end

   always_comb begin
      ld_voxel.first = req_chan.first;
      ld_voxel.x     = req_chan.pos_x;
      ld_voxel.y     = req_chan.pos_y;
      ld_voxel.z     = req_chan.pos_z;
      ld_voxel.kind  = req_chan.self_type;
      ld_voxel.water = self_water;
      ld_voxel.mask  = self_air ? '0 : lane_vis;
   end

   assign req_chan.ready = ld_ready;

   vfc_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .ld_valid (req_chan.valid),
      .ld_voxel (ld_voxel),
      .ld_ready (ld_ready),
      .rsp_chan (rsp_chan)
   );
endmodule
`default_nettype wire
